// ===== rtl/thkbd_pkg.sv =====
// shared constants, types and coefficient rom for the boundary displacement block
`default_nettype none

package thkbd_pkg;

    localparam int MAX_HALF_WIDTH_DEF = 10;
    localparam int DISP_WIDTH_DEF     = 32;
    localparam int COEF_FRAC_BITS_DEF = 23;

    localparam int ROM_FRAC   = 23;
    localparam int ROM_CENTER = 10;
    localparam int ROM_DEPTH  = 21;
    localparam int ROM_IDX_W  = 5;
    localparam int SUM_WIDTH  = 56;
    localparam int CNT_W      = 5;
    localparam int NCRIT_W    = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

    localparam logic MODE_TERM   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    // matrix element positions inside one rom row
    localparam logic [1:0] POS_T00 = 2'd0;
    localparam logic [1:0] POS_T01 = 2'd1;
    localparam logic [1:0] POS_T10 = 2'd2;
    localparam logic [1:0] POS_T11 = 2'd3;

    // output tdata width: disp_x, disp_y rounded up to bytes
    localparam int OUT_W_DEF = ((2 * DISP_WIDTH_DEF) + 7) / 8 * 8;

    // control bits that travel with a beat down the pipeline
    typedef struct packed {
        logic fin;      // finish beat
        logic acc;      // term beat inside the expected count
        logic cnt_err;  // term count differs from 2*min(ncrit, max half width)+1
    } t_ctl;

    // theta(k), k = -10..10 at row k+10: t00, t01, t10, t11 in q0.23
    localparam int THETA_ROM [ROM_DEPTH][4] = '{
        '{  31314,    1743,    1698,   10574},
        '{  38205,    2357,    2281,   12941},
        '{  47630,    3296,    3161,   16205},
        '{  60982,    4809,    4549,   20887},
        '{  80727,    7400,    6857,   27947},
        '{ 111501,   12193,   10942,   39314},
        '{ 162634,   21936,   18753,   59319},
        '{ 254387,   44124,   35240,   99224},
        '{ 434583,  101906,   75604,  195326},
        '{ 828366,  279268,  210146,  516549},
        '{1829236,  974177, 1436082, 3090708},
        '{1829236, -974177,-1436082, 3090708},
        '{ 828366, -279268, -210146,  516549},
        '{ 434583, -101906,  -75604,  195326},
        '{ 254387,  -44124,  -35240,   99224},
        '{ 162634,  -21936,  -18753,   59319},
        '{ 111501,  -12193,  -10942,   39314},
        '{  80727,   -7400,   -6857,   27947},
        '{  60982,   -4809,   -4549,   20887},
        '{  47630,   -3296,   -3161,   16205},
        '{  38205,   -2357,   -2281,   12941}
    };

    // rom coefficient rescaled to cfb fraction bits, round half up
    function automatic longint coef_q(input logic [ROM_IDX_W-1:0] idx,
                                      input logic [1:0] pos,
                                      input int cfb);
        longint c;
        c = 0;
        if (int'(idx) < ROM_DEPTH) begin
            c = longint'(THETA_ROM[idx][pos]);
        end
        if (cfb >= ROM_FRAC) begin
            return c <<< (cfb - ROM_FRAC);
        end
        return (c + (64'sd1 <<< (ROM_FRAC - 1 - cfb))) >>> (ROM_FRAC - cfb);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/thkbd_front.sv =====
// input stage: term counting, coefficient lookup and neighbor difference
`default_nettype none

module thkbd_front #(
    parameter int MAX_HALF_WIDTH = 10,
    parameter int DISP_WIDTH     = 32,
    parameter int COEF_FRAC_BITS = 23
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic                                 i_mode,
    input  wire logic                                 i_near_valid,
    input  wire logic signed [DISP_WIDTH-1:0]         i_near_x,
    input  wire logic signed [DISP_WIDTH-1:0]         i_near_y,
    input  wire logic                                 i_far_valid,
    input  wire logic signed [DISP_WIDTH-1:0]         i_far_x,
    input  wire logic signed [DISP_WIDTH-1:0]         i_far_y,
    input  wire logic signed [DISP_WIDTH-1:0]         i_anchor_x,
    input  wire logic signed [DISP_WIDTH-1:0]         i_anchor_y,
    input  wire logic [thkbd_pkg::NCRIT_W-1:0]        i_ncrit,
    input  wire logic                                 i_free,
    output logic                                      o_valid,
    output thkbd_pkg::t_ctl                           o_ctl,
    output logic signed [DISP_WIDTH:0]                o_dx,
    output logic signed [DISP_WIDTH:0]                o_dy,
    output logic signed [COEF_FRAC_BITS:0]            o_coef [4],
    output logic signed [DISP_WIDTH-1:0]              o_anchor_x,
    output logic signed [DISP_WIDTH-1:0]              o_anchor_y
);
    import thkbd_pkg::*;

    localparam int COEF_W = COEF_FRAC_BITS + 1;
    localparam int DIFF_W = DISP_WIDTH + 1;

    logic [CNT_W-1:0]            r_count, n_count;
    logic                        r_valid;
    t_ctl                        r_ctl, n_ctl;
    logic signed [DIFF_W-1:0]    r_dx, r_dy, n_dx, n_dy;
    logic signed [COEF_W-1:0]    r_coef [4];
    logic signed [COEF_W-1:0]    n_coef [4];
    logic signed [DISP_WIDTH-1:0] r_anchor_x, r_anchor_y;

    logic [NCRIT_W-1:0]          half;
    logic [CNT_W-1:0]            expected;
    logic [ROM_IDX_W-1:0]        rom_idx;
    logic signed [DIFF_W-1:0]    nx, ny, fx, fy;
    logic                        accept;

    assign o_ready = !r_valid || i_free;
    assign accept  = i_valid && o_ready;

    always_comb begin
        half     = (i_ncrit > NCRIT_W'(MAX_HALF_WIDTH)) ? NCRIT_W'(MAX_HALF_WIDTH) : i_ncrit;
        expected = CNT_W'({half, 1'b1});
        // coefficient taken at offset -j, j = count - half
        rom_idx  = ROM_IDX_W'(ROM_CENTER) + ROM_IDX_W'(half) - ROM_IDX_W'(r_count);

        n_ctl.fin     = (i_mode == MODE_FINISH);
        n_ctl.acc     = (i_mode == MODE_TERM) && (r_count < expected);
        n_ctl.cnt_err = (r_count != expected);

        // a missing neighbor counts as zero
        nx = i_near_valid ? DIFF_W'(i_near_x) : '0;
        ny = i_near_valid ? DIFF_W'(i_near_y) : '0;
        fx = i_far_valid  ? DIFF_W'(i_far_x)  : '0;
        fy = i_far_valid  ? DIFF_W'(i_far_y)  : '0;
        n_dx = nx - fx;
        n_dy = ny - fy;

        for (int k = 0; k < 4; k++) begin
            n_coef[k] = COEF_W'(coef_q(rom_idx, 2'(k), COEF_FRAC_BITS));
        end

        n_count = r_count;
        if (accept) begin
            if (i_mode == MODE_FINISH) begin
                n_count = '0;
            end else if (r_count != CNT_MAX) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
            r_ctl   <= '0;
        end else begin
            r_count <= n_count;
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_ctl <= n_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dx       <= n_dx;
            r_dy       <= n_dy;
            r_coef     <= n_coef;
            r_anchor_x <= i_anchor_x;
            r_anchor_y <= i_anchor_y;
        end
    end

    assign o_valid    = r_valid;
    assign o_ctl      = r_ctl;
    assign o_dx       = r_dx;
    assign o_dy       = r_dy;
    assign o_coef     = r_coef;
    assign o_anchor_x = r_anchor_x;
    assign o_anchor_y = r_anchor_y;

endmodule

`default_nettype wire

// ===== rtl/thkbd_mul.sv =====
// product stage: four coefficient by difference multiplies, registered
`default_nettype none

module thkbd_mul #(
    parameter int DISP_WIDTH     = 32,
    parameter int COEF_FRAC_BITS = 23
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_valid,
    input  wire thkbd_pkg::t_ctl                               i_ctl,
    input  wire logic signed [DISP_WIDTH:0]                    i_dx,
    input  wire logic signed [DISP_WIDTH:0]                    i_dy,
    input  wire logic signed [COEF_FRAC_BITS:0]                i_coef [4],
    input  wire logic signed [DISP_WIDTH-1:0]                  i_anchor_x,
    input  wire logic signed [DISP_WIDTH-1:0]                  i_anchor_y,
    input  wire logic                                          i_ready,
    output logic                                               o_free,
    output logic                                               o_valid,
    output thkbd_pkg::t_ctl                                    o_ctl,
    output logic signed [DISP_WIDTH+COEF_FRAC_BITS+1:0]        o_prod [4],
    output logic signed [DISP_WIDTH-1:0]                       o_anchor_x,
    output logic signed [DISP_WIDTH-1:0]                       o_anchor_y
);
    import thkbd_pkg::*;

    localparam int P_W = DISP_WIDTH + COEF_FRAC_BITS + 2;

    logic                         r_valid;
    t_ctl                         r_ctl;
    logic signed [P_W-1:0]        r_prod [4];
    logic signed [DISP_WIDTH-1:0] r_anchor_x, r_anchor_y;
    logic                         load;

    assign o_free = !r_valid || i_ready;
    assign load   = i_valid && o_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ctl   <= '0;
        end else begin
            if (o_free) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_ctl <= i_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_prod[POS_T00] <= P_W'(i_coef[POS_T00]) * P_W'(i_dx);
            r_prod[POS_T01] <= P_W'(i_coef[POS_T01]) * P_W'(i_dy);
            r_prod[POS_T10] <= P_W'(i_coef[POS_T10]) * P_W'(i_dx);
            r_prod[POS_T11] <= P_W'(i_coef[POS_T11]) * P_W'(i_dy);
            r_anchor_x      <= i_anchor_x;
            r_anchor_y      <= i_anchor_y;
        end
    end

    assign o_valid    = r_valid;
    assign o_ctl      = r_ctl;
    assign o_prod     = r_prod;
    assign o_anchor_x = r_anchor_x;
    assign o_anchor_y = r_anchor_y;

endmodule

`default_nettype wire

// ===== rtl/thkbd_acc.sv =====
// accumulate stage: rounding, saturating sums and the result register
`default_nettype none

module thkbd_acc #(
    parameter int DISP_WIDTH     = 32,
    parameter int COEF_FRAC_BITS = 23
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_valid,
    input  wire thkbd_pkg::t_ctl                               i_ctl,
    input  wire logic signed [DISP_WIDTH+COEF_FRAC_BITS+1:0]   i_prod [4],
    input  wire logic signed [DISP_WIDTH-1:0]                  i_anchor_x,
    input  wire logic signed [DISP_WIDTH-1:0]                  i_anchor_y,
    output logic                                               o_ready,
    input  wire logic                                          i_out_ready,
    output logic                                               o_out_valid,
    output logic signed [DISP_WIDTH-1:0]                       o_disp_x,
    output logic signed [DISP_WIDTH-1:0]                       o_disp_y,
    output logic                                               o_count_error,
    output logic                                               o_saturated
);
    import thkbd_pkg::*;

    localparam int P_W  = DISP_WIDTH + COEF_FRAC_BITS + 2;
    localparam int RW   = P_W + 1;
    localparam int T_W  = RW - COEF_FRAC_BITS;
    localparam int SW   = SUM_WIDTH;
    localparam int WW   = SUM_WIDTH + 1;
    localparam logic signed [RW-1:0]         HALF     = RW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SW-1:0]         SUM_MAX  = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0]         SUM_MIN  = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [DISP_WIDTH-1:0] DISP_MAX = {1'b0, {(DISP_WIDTH-1){1'b1}}};
    localparam logic signed [DISP_WIDTH-1:0] DISP_MIN = {1'b1, {(DISP_WIDTH-1){1'b0}}};
    localparam int HI_W = WW - DISP_WIDTH + 1;

    logic signed [SW-1:0]         r_sum_x, r_sum_y, n_sum_x, n_sum_y;
    logic                         r_clip;
    logic                         r_out_valid;
    logic signed [DISP_WIDTH-1:0] r_disp_x, r_disp_y, n_disp_x, n_disp_y;
    logic                         r_count_error;
    logic                         r_saturated;

    logic signed [RW-1:0]         row_x, row_y;
    logic signed [T_W-1:0]        term_x, term_y;
    logic signed [WW-1:0]         wide_x, wide_y, out_x, out_y;
    logic                         clip_x, clip_y, oclip_x, oclip_y;
    logic                         out_free, take;

    assign out_free = !r_out_valid || i_out_ready;
    assign o_ready  = !(i_valid && i_ctl.fin) || out_free;
    assign take     = i_valid && o_ready;

    always_comb begin
        // round half up, then drop the fraction
        row_x  = RW'(i_prod[POS_T00]) + RW'(i_prod[POS_T01]) + HALF;
        row_y  = RW'(i_prod[POS_T10]) + RW'(i_prod[POS_T11]) + HALF;
        term_x = $signed(row_x[RW-1:COEF_FRAC_BITS]);
        term_y = $signed(row_y[RW-1:COEF_FRAC_BITS]);

        wide_x = WW'(r_sum_x) + WW'(term_x);
        wide_y = WW'(r_sum_y) + WW'(term_y);
        clip_x = wide_x[WW-1] != wide_x[WW-2];
        clip_y = wide_y[WW-1] != wide_y[WW-2];
        n_sum_x = clip_x ? (wide_x[WW-1] ? SUM_MIN : SUM_MAX) : wide_x[SW-1:0];
        n_sum_y = clip_y ? (wide_y[WW-1] ? SUM_MIN : SUM_MAX) : wide_y[SW-1:0];

        out_x   = WW'(r_sum_x) + WW'(i_anchor_x);
        out_y   = WW'(r_sum_y) + WW'(i_anchor_y);
        oclip_x = (out_x[WW-1:DISP_WIDTH-1] != '0) && (out_x[WW-1:DISP_WIDTH-1] != {HI_W{1'b1}});
        oclip_y = (out_y[WW-1:DISP_WIDTH-1] != '0) && (out_y[WW-1:DISP_WIDTH-1] != {HI_W{1'b1}});
        n_disp_x = oclip_x ? (out_x[WW-1] ? DISP_MIN : DISP_MAX) : out_x[DISP_WIDTH-1:0];
        n_disp_y = oclip_y ? (out_y[WW-1] ? DISP_MIN : DISP_MAX) : out_y[DISP_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take && i_ctl.fin) begin
                r_sum_x     <= '0;
                r_sum_y     <= '0;
                r_clip      <= 1'b0;
                r_out_valid <= 1'b1;
            end else begin
                if (take && i_ctl.acc) begin
                    r_sum_x <= n_sum_x;
                    r_sum_y <= n_sum_y;
                    r_clip  <= r_clip | clip_x | clip_y;
                end
                if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_ctl.fin) begin
            r_disp_x      <= n_disp_x;
            r_disp_y      <= n_disp_y;
            r_count_error <= i_ctl.cnt_err;
            r_saturated   <= r_clip | oclip_x | oclip_y;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_disp_x      = r_disp_x;
    assign o_disp_y      = r_disp_y;
    assign o_count_error = r_count_error;
    assign o_saturated   = r_saturated;

endmodule

`default_nettype wire

// ===== rtl/thk_boundary_displacement.sv =====
// top level of the time history kernel boundary displacement block
//
// computes one boundary atom displacement from a stream of kernel terms
// input stream (s side): one beat per term, tuser = mode; a term beat (mode 0)
//   carries the row-0 and row-1 neighbor displacements, a finish beat (mode 1)
//   carries the anchor displacement and closes the run
// the block counts term beats itself: beat k of a run is kernel offset
//   j = k - ncrit, weighted by the 2x2 matrix theta(-j) from a constant rom
// output stream (m side): one beat per finish beat with the saturated
//   displacement in tdata and count_error, saturated in tuser
// config: i_cfg_wen writes ncrit (kernel half width); the user must write it
//   only while idle, the block itself does not enforce this
// throughput: one beat per clock on the input side, terms and finishes alike,
//   while no finish beat waits for the output register; the three register
//   stages are input, product (the four multiplies per term) and result
// stall: term beats keep flowing while a result waits in the output register;
//   a finish beat waits in the product stage until the output register is free,
//   and o_s_tready drops combinationally once the input stage holds a beat
// reset: i_rst_n synchronous, clears sums, term count, clip flag, ncrit and
//   all stage valids
`default_nettype none

module thk_boundary_displacement #(
    parameter int MAX_HALF_WIDTH = thkbd_pkg::MAX_HALF_WIDTH_DEF,
    parameter int DISP_WIDTH     = thkbd_pkg::DISP_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = thkbd_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // slave side: terms and finish beats
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,
    // near_valid, near_x, near_y, far_valid, far_x, far_y, anchor_x, anchor_y
    input  wire logic [((2 + 6 * DISP_WIDTH) + 7) / 8 * 8 - 1:0] i_s_tdata,
    // mode
    input  wire logic                                  i_s_tuser,
    // master side: results
    output logic                                       o_m_tvalid,
    input  wire logic                                  i_m_tready,
    // disp_x, disp_y
    output logic [((2 * DISP_WIDTH) + 7) / 8 * 8 - 1:0] o_m_tdata,
    // count_error, saturated
    output logic [1:0]                                 o_m_tuser,
    // configuration: ncrit
    input  wire logic                                  i_cfg_wen,
    input  wire logic [thkbd_pkg::NCRIT_W-1:0]         i_cfg_wdata
);
    import thkbd_pkg::*;

    localparam int D      = DISP_WIDTH;
    localparam int OUT_W  = ((2 * D) + 7) / 8 * 8;
    localparam int COEF_W = COEF_FRAC_BITS + 1;
    localparam int P_W    = D + COEF_FRAC_BITS + 2;

    // tdata bit offsets, lowest field first
    localparam int OFS_NEAR_V = 0;
    localparam int OFS_NEAR_X = 1;
    localparam int OFS_NEAR_Y = OFS_NEAR_X + D;
    localparam int OFS_FAR_V  = OFS_NEAR_Y + D;
    localparam int OFS_FAR_X  = OFS_FAR_V + 1;
    localparam int OFS_FAR_Y  = OFS_FAR_X + D;
    localparam int OFS_ANC_X  = OFS_FAR_Y + D;
    localparam int OFS_ANC_Y  = OFS_ANC_X + D;

    logic [NCRIT_W-1:0] r_ncrit;

    // unpacked input fields
    logic                 near_valid, far_valid;
    logic signed [D-1:0]  near_x, near_y, far_x, far_y, anchor_x, anchor_y;

    // stage 1 (front to multiply)
    logic                 s1_valid;
    t_ctl                 s1_ctl;
    logic signed [D:0]    s1_dx, s1_dy;
    logic signed [COEF_W-1:0] s1_coef [4];
    logic signed [D-1:0]  s1_anchor_x, s1_anchor_y;
    logic                 s2_free;

    // stage 2 (multiply to accumulate)
    logic                 s2_valid;
    t_ctl                 s2_ctl;
    logic signed [P_W-1:0] s2_prod [4];
    logic signed [D-1:0]  s2_anchor_x, s2_anchor_y;
    logic                 s3_ready;

    // result
    logic signed [D-1:0]  disp_x, disp_y;
    logic                 count_error, saturated;

    assign near_valid = i_s_tdata[OFS_NEAR_V];
    assign near_x     = i_s_tdata[OFS_NEAR_X +: D];
    assign near_y     = i_s_tdata[OFS_NEAR_Y +: D];
    assign far_valid  = i_s_tdata[OFS_FAR_V];
    assign far_x      = i_s_tdata[OFS_FAR_X +: D];
    assign far_y      = i_s_tdata[OFS_FAR_Y +: D];
    assign anchor_x   = i_s_tdata[OFS_ANC_X +: D];
    assign anchor_y   = i_s_tdata[OFS_ANC_Y +: D];

    // half width: user must write it only between runs, block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncrit <= '0;
        end else if (i_cfg_wen) begin
            r_ncrit <= i_cfg_wdata;
        end
    end

    thkbd_front #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .DISP_WIDTH     (D),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_mode       (i_s_tuser),
        .i_near_valid (near_valid),
        .i_near_x     (near_x),
        .i_near_y     (near_y),
        .i_far_valid  (far_valid),
        .i_far_x      (far_x),
        .i_far_y      (far_y),
        .i_anchor_x   (anchor_x),
        .i_anchor_y   (anchor_y),
        .i_ncrit      (r_ncrit),
        .i_free       (s2_free),
        .o_valid      (s1_valid),
        .o_ctl        (s1_ctl),
        .o_dx         (s1_dx),
        .o_dy         (s1_dy),
        .o_coef       (s1_coef),
        .o_anchor_x   (s1_anchor_x),
        .o_anchor_y   (s1_anchor_y)
    );

    thkbd_mul #(
        .DISP_WIDTH     (D),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s1_valid),
        .i_ctl      (s1_ctl),
        .i_dx       (s1_dx),
        .i_dy       (s1_dy),
        .i_coef     (s1_coef),
        .i_anchor_x (s1_anchor_x),
        .i_anchor_y (s1_anchor_y),
        .i_ready    (s3_ready),
        .o_free     (s2_free),
        .o_valid    (s2_valid),
        .o_ctl      (s2_ctl),
        .o_prod     (s2_prod),
        .o_anchor_x (s2_anchor_x),
        .o_anchor_y (s2_anchor_y)
    );

    thkbd_acc #(
        .DISP_WIDTH     (D),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_acc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s2_valid),
        .i_ctl         (s2_ctl),
        .i_prod        (s2_prod),
        .i_anchor_x    (s2_anchor_x),
        .i_anchor_y    (s2_anchor_y),
        .o_ready       (s3_ready),
        .i_out_ready   (i_m_tready),
        .o_out_valid   (o_m_tvalid),
        .o_disp_x      (disp_x),
        .o_disp_y      (disp_y),
        .o_count_error (count_error),
        .o_saturated   (saturated)
    );

    // result beat packing, padded to whole bytes
    assign o_m_tdata = OUT_W'({disp_y, disp_x});
    assign o_m_tuser = {saturated, count_error};

endmodule

`default_nettype wire

// ===== rtl/thkbd_checker.sv =====
// port level checks for the boundary displacement block, bound to the top level
`default_nettype none

module thkbd_checker #(
    parameter int OUT_W = thkbd_pkg::OUT_W_DEF
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             o_s_tready,
    input wire logic             o_m_tvalid,
    input wire logic             i_m_tready,
    input wire logic [OUT_W-1:0] o_m_tdata,
    input wire logic [1:0]       o_m_tuser
);

    // a result beat is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result payload changed while stalled");

    // the pipeline stalls only when the output register is full and blocked
    a_in_ready: assert property (@(posedge i_clk)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled with a free result register");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat present after reset");

endmodule

bind thk_boundary_displacement thkbd_checker #(
    .OUT_W (OUT_W)
) u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

// ===== verif/thk_boundary_displacement_tb.sv =====
// testbench for the boundary displacement block: kernel term stream, finish beats, result checks
`timescale 1ns / 100ps

module thk_boundary_displacement_tb;

    import thkbd_pkg::*;

    // widths as the block is built with its default parameters
    localparam int DW       = DISP_WIDTH_DEF;
    localparam int S_DATA_W = ((2 + 6 * DW) + 7) / 8 * 8;
    localparam int M_DATA_W = ((2 * DW) + 7) / 8 * 8;

    // fixed point of the kernel: rom and products both use 23 fraction bits
    localparam int COEF_FRAC    = 23;
    localparam int KERNEL_MID   = 10;
    localparam int TERM_CNT_MAX = 31;

    // run shaping
    localparam int PHASE_ITEMS  = 310;   // input beats per random phase
    localparam int DRAIN_CYCLES = 8;     // three register stages plus margin
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int TIMEOUT_NS   = 400000;

    // theta(k) for k = -10..10 at row k+10: t00, t01, t10, t11 in q0.23
    localparam int KERNEL_THETA [21][4] = '{
        '{  31314,    1743,    1698,   10574},
        '{  38205,    2357,    2281,   12941},
        '{  47630,    3296,    3161,   16205},
        '{  60982,    4809,    4549,   20887},
        '{  80727,    7400,    6857,   27947},
        '{ 111501,   12193,   10942,   39314},
        '{ 162634,   21936,   18753,   59319},
        '{ 254387,   44124,   35240,   99224},
        '{ 434583,  101906,   75604,  195326},
        '{ 828366,  279268,  210146,  516549},
        '{1829236,  974177, 1436082, 3090708},
        '{1829236, -974177,-1436082, 3090708},
        '{ 828366, -279268, -210146,  516549},
        '{ 434583, -101906,  -75604,  195326},
        '{ 254387,  -44124,  -35240,   99224},
        '{ 162634,  -21936,  -18753,   59319},
        '{ 111501,  -12193,  -10942,   39314},
        '{  80727,   -7400,   -6857,   27947},
        '{  60982,   -4809,   -4549,   20887},
        '{  47630,   -3296,   -3161,   16205},
        '{  38205,   -2357,   -2281,   12941}
    };

    // one input beat, unpacked
    typedef struct {
        logic          mode;
        logic          near_valid;
        logic [DW-1:0] near_x;
        logic [DW-1:0] near_y;
        logic          far_valid;
        logic [DW-1:0] far_x;
        logic [DW-1:0] far_y;
        logic [DW-1:0] anchor_x;
        logic [DW-1:0] anchor_y;
    } t_kernel_beat;

    // one result beat, unpacked
    typedef struct {
        logic [DW-1:0] disp_x;
        logic [DW-1:0] disp_y;
        logic          count_error;
        logic          saturated;
    } t_disp_result;

    // dut ports; the inputs are known from time zero
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_s_tvalid  = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata   = '0;
    logic                i_s_tuser   = MODE_TERM;
    logic                o_m_tvalid;
    logic                i_m_tready  = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;
    logic [1:0]          o_m_tuser;
    logic                i_cfg_wen   = 1'b0;
    logic [NCRIT_W-1:0]  i_cfg_wdata = '0;

    // shadow of the block state for prediction
    logic [NCRIT_W-1:0] half_width = '0;
    longint             kern_sum_x = 0;
    longint             kern_sum_y = 0;
    int                 terms_seen = 0;
    logic               sum_clipped = 1'b0;

    // displacements still to come out of the block, oldest first
    t_disp_result disp_due [$];

    // idle control: percent of cycles each side holds off
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_toggle   = 1'b0;
    logic hold_ack      = 1'b0;
    int   hold_left     = 0;

    // run bookkeeping
    int errors       = 0;
    int beats_sent   = 0;
    int results_seen = 0;
    int width_writes = 0;

    always #1 i_clk = ~i_clk;

    thk_boundary_displacement uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        // near_valid, near_x, near_y, far_valid, far_x, far_y, anchor_x, anchor_y
        .i_s_tdata   (i_s_tdata),
        // mode
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        // disp_x, disp_y
        .o_m_tdata   (o_m_tdata),
        // count_error, saturated
        .o_m_tuser   (o_m_tuser),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // clip v to a signed w-bit range, flag any clipping
    task automatic clip_signed(input longint v, input int w, output longint r,
                               inout logic hit);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        r = v;
        if (v > hi) begin
            r = hi;
            hit = 1'b1;
        end else if (v < lo) begin
            r = lo;
            hit = 1'b1;
        end
    endtask

    // one matrix row times the difference vector, round half up;
    // products stay below 2^56 so longint holds them exactly
    function automatic longint theta_row(input longint a, input longint b,
                                         input longint dx, input longint dy);
        return (a * dx + b * dy + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    endfunction

    // advance the shadow state by one accepted beat
    task automatic predict_beat(input t_kernel_beat b);
        int           n;
        int           need;
        int           row;
        longint       nx;
        longint       ny;
        longint       fx;
        longint       fy;
        longint       dx;
        longint       dy;
        longint       ox;
        longint       oy;
        logic         clip;
        t_disp_result res;
        n = (half_width > MAX_HALF_WIDTH_DEF) ? MAX_HALF_WIDTH_DEF : int'(half_width);
        need = 2 * n + 1;
        if (b.mode == MODE_TERM) begin
            // terms past the expected count only bump the counter
            if (terms_seen < need) begin
                nx = 0; ny = 0; fx = 0; fy = 0;
                // a missing neighbor counts as zero displacement
                if (b.near_valid) begin
                    nx = $signed(b.near_x);
                    ny = $signed(b.near_y);
                end
                if (b.far_valid) begin
                    fx = $signed(b.far_x);
                    fy = $signed(b.far_y);
                end
                dx = nx - fx;
                dy = ny - fy;
                // term k of a run is offset j = k - n, weighted by theta(-j)
                row = KERNEL_MID + n - terms_seen;
                clip_signed(kern_sum_x + theta_row(KERNEL_THETA[row][0], KERNEL_THETA[row][1],
                            dx, dy), SUM_WIDTH, kern_sum_x, sum_clipped);
                clip_signed(kern_sum_y + theta_row(KERNEL_THETA[row][2], KERNEL_THETA[row][3],
                            dx, dy), SUM_WIDTH, kern_sum_y, sum_clipped);
            end
            if (terms_seen < TERM_CNT_MAX) begin
                terms_seen++;
            end
        end else begin
            clip = sum_clipped;
            clip_signed(kern_sum_x + longint'($signed(b.anchor_x)), DW, ox, clip);
            clip_signed(kern_sum_y + longint'($signed(b.anchor_y)), DW, oy, clip);
            res.disp_x      = ox[DW-1:0];
            res.disp_y      = oy[DW-1:0];
            res.count_error = (terms_seen != need);
            res.saturated   = clip;
            disp_due.push_back(res);
            kern_sum_x  = 0;
            kern_sum_y  = 0;
            terms_seen  = 0;
            sum_clipped = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // mostly small values, plenty of full range, some rails and zero
    function automatic logic [DW-1:0] rand_disp();
        logic [31:0] v;
        int          r;
        v = $urandom;
        r = $urandom_range(99);
        if (r < 45) begin
            return {{6{v[25]}}, v[25:0]};
        end else if (r < 80) begin
            return v;
        end else if (r < 87) begin
            return 32'h7fff_ffff;
        end else if (r < 94) begin
            return 32'h8000_0000;
        end
        return '0;
    endfunction

    // random beat; unused fields still carry random content
    function automatic t_kernel_beat rand_beat(input logic mode);
        t_kernel_beat b;
        b.mode       = mode;
        b.near_valid = ($urandom_range(99) < 85);
        b.near_x     = rand_disp();
        b.near_y     = rand_disp();
        b.far_valid  = ($urandom_range(99) < 85);
        b.far_x      = rand_disp();
        b.far_y      = rand_disp();
        b.anchor_x   = rand_disp();
        b.anchor_y   = rand_disp();
        return b;
    endfunction

    function automatic t_kernel_beat make_beat(input logic mode,
                                               input logic nv, input logic [DW-1:0] nx,
                                               input logic [DW-1:0] ny,
                                               input logic fv, input logic [DW-1:0] fx,
                                               input logic [DW-1:0] fy,
                                               input logic [DW-1:0] ax,
                                               input logic [DW-1:0] ay);
        t_kernel_beat b;
        b.mode = mode;
        b.near_valid = nv; b.near_x = nx; b.near_y = ny;
        b.far_valid  = fv; b.far_x  = fx; b.far_y  = fy;
        b.anchor_x   = ax; b.anchor_y = ay;
        return b;
    endfunction

    // kernel half width for a new set of runs, extremes favored
    function automatic logic [NCRIT_W-1:0] pick_half_width();
        int r;
        r = $urandom_range(99);
        if (r < 20) begin
            return '0;
        end else if (r < 40) begin
            return NCRIT_W'(MAX_HALF_WIDTH_DEF);
        end else if (r < 55) begin
            return NCRIT_W'($urandom_range(15, MAX_HALF_WIDTH_DEF + 1));
        end
        return NCRIT_W'($urandom_range(MAX_HALF_WIDTH_DEF - 1, 1));
    endfunction

    // offer one beat, with random idle cycles ahead of it, until accepted;
    // called at a rising edge, returns at the edge that took the beat
    task automatic send_beat(input t_kernel_beat b);
        logic [S_DATA_W-1:0] word;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        word = '0;
        word[2 + 6 * DW - 1:0] = {b.anchor_y, b.anchor_x, b.far_y, b.far_x, b.far_valid,
                                  b.near_y, b.near_x, b.near_valid};
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        i_s_tuser  <= b.mode;
        do @(posedge i_clk); while (!o_s_tready);
        predict_beat(b);
        beats_sent++;
    endtask

    // a run of random terms closed by a random finish beat
    task automatic send_run(input int n_terms);
        for (int k = 0; k < n_terms; k++) begin
            send_beat(rand_beat(MODE_TERM));
        end
        send_beat(rand_beat(MODE_FINISH));
    endtask

    // stop offering, wait for every pending result and for the pipeline to empty
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (disp_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write the kernel half width while the block is idle
    task automatic set_half_width(input logic [NCRIT_W-1:0] w);
        wait_drained();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        half_width = w;
        width_writes++;
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // width from reset is zero: one term, then finish; top rails clip the output
    task automatic test_reset_width();
        send_beat(make_beat(MODE_TERM, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff,
                            1'b0, 32'h8000_0000, 32'h8000_0000, '0, '0));
        send_beat(make_beat(MODE_FINISH, 1'b0, '0, '0, 1'b0, '0, '0,
                            32'h7fff_ffff, 32'h7fff_ffff));
    endtask

    // missing neighbors count as zero, neighbor fields on finish are ignored
    task automatic test_missing_neighbor();
        send_beat(make_beat(MODE_TERM, 1'b0, 32'h1234_5678, 32'h8765_4321,
                            1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, '0));
        send_beat(make_beat(MODE_FINISH, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff,
                            1'b1, 32'h8000_0000, 32'h8000_0000, 32'h0100_0000, 32'hff00_0000));
        send_beat(make_beat(MODE_TERM, 1'b0, 32'h7fff_ffff, 32'h7fff_ffff,
                            1'b1, 32'h0040_0000, 32'hffc0_0000, '0, '0));
        send_beat(make_beat(MODE_FINISH, 1'b0, '0, '0, 1'b0, '0, '0, '0, 32'h0000_0001));
    endtask

    // short and long runs raise count_error; extra terms are not summed
    task automatic test_term_counts();
        set_half_width(NCRIT_W'(1));
        send_beat(make_beat(MODE_FINISH, 1'b1, 32'h0100_0000, '0, 1'b1, '0, '0,
                            32'h0080_0000, 32'hff80_0000));
        send_run(2);
        send_run(4);
        send_run(3);
    endtask

    // bottom rails drive the output into negative clipping
    task automatic test_output_clip();
        set_half_width('0);
        send_beat(make_beat(MODE_TERM, 1'b1, 32'h8000_0000, 32'h8000_0000,
                            1'b1, 32'h7fff_ffff, 32'h7fff_ffff, '0, '0));
        send_beat(make_beat(MODE_FINISH, 1'b0, '0, '0, 1'b0, '0, '0,
                            32'h8000_0000, 32'h8000_0000));
    endtask

    // receiver holds off for a long stretch while beats keep coming,
    // so results back up and the input side stalls
    task automatic test_output_stall();
        set_half_width(NCRIT_W'(1));
        send_idle_pct = 0;
        hold_toggle <= ~hold_toggle;
        for (int k = 0; k < 4; k++) begin
            send_run(3);
        end
        for (int k = 0; k < 6; k++) begin
            send_beat(rand_beat(MODE_FINISH));
        end
    endtask

    // mostly well formed runs, some short, long or count saturating
    task automatic test_random_stream(input int tx_idle, input int rx_idle,
                                      input logic [NCRIT_W-1:0] first_width);
        int start;
        int runs;
        int n;
        int need;
        int r;
        send_idle_pct = tx_idle;
        recv_idle_pct <= rx_idle;
        set_half_width(first_width);
        start = beats_sent;
        runs  = 0;
        while (beats_sent - start < PHASE_ITEMS) begin
            if (runs != 0 && runs % 4 == 0) begin
                set_half_width(pick_half_width());
            end
            n = (half_width > MAX_HALF_WIDTH_DEF) ? MAX_HALF_WIDTH_DEF : int'(half_width);
            need = 2 * n + 1;
            r = $urandom_range(99);
            if (r < 75) begin
                send_run(need);
            end else if (r < 85) begin
                send_run($urandom_range(need - 1, 0));
            end else if (r < 95) begin
                send_run($urandom_range(need + 3, need + 1));
            end else begin
                send_run($urandom_range(34, 32));
            end
            runs++;
        end
    endtask

    // ---------------------------------------------------------------
    // receiver: random ready, plus a long hold-off on request
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_toggle != hold_ack) begin
            hold_ack   <= hold_toggle;
            hold_left  <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // result checker: every accepted result beat against the oldest prediction
    // ---------------------------------------------------------------
    task automatic check_field(input string what, input logic [DW-1:0] want,
                               input logic [DW-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_disp_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (disp_due.size() == 0) begin
                errors++;
                $display("%0t ns: result beat with none pending, actual %h / %b",
                         $time, o_m_tdata, o_m_tuser);
            end else begin
                want = disp_due.pop_front();
                results_seen++;
                check_field("disp_x", want.disp_x, o_m_tdata[DW-1:0]);
                check_field("disp_y", want.disp_y, o_m_tdata[2*DW-1:DW]);
                check_field("count_error", DW'(want.count_error), DW'(o_m_tuser[0]));
                check_field("saturated", DW'(want.saturated), DW'(o_m_tuser[1]));
            end
        end
    end

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_width();
        test_missing_neighbor();
        test_term_counts();
        test_output_clip();
        test_output_stall();

        // sender idles 30, receiver 68; then swapped; then no idling
        test_random_stream(30, 68, NCRIT_W'(15));
        test_random_stream(68, 30, NCRIT_W'(MAX_HALF_WIDTH_DEF));
        test_random_stream(0, 0, '0);

        wait_drained();

        $display("run covered %0d input beats and %0d checked results", beats_sent, results_seen);
        $display("across %0d kernel width writes, short, long and saturating runs, clipping",
                 width_writes);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // hard stop if the handshakes ever hang
    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
